// ===== rtl/qwt_pkg.sv =====
// ----------------------------------------------------------------------------
// qwt_pkg
// Shared types and constants for the quoted word tokenizer: request and
// result payloads, scan modes, configuration register indexes.
// ----------------------------------------------------------------------------
package qwt_pkg;

	// Default width of the per-line word counter
	localparam int COUNT_BITS_DEF = 8;

	// Special bytes
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_NUL       = 8'h00;

	// Separator register file
	localparam int         SEP_REGS      = 4;
	localparam logic [2:0] SEP_COUNT_RST = 3'd3;
	localparam logic [7:0] SEP_A_RST     = 8'd32;
	localparam logic [7:0] SEP_B_RST     = 8'd9;
	localparam logic [7:0] SEP_C_RST     = 8'd10;
	localparam logic [7:0] SEP_D_RST     = 8'd0;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_SEP_COUNT  = 3'd0,
		CFG_SEP_CHAR_A = 3'd1,
		CFG_SEP_CHAR_B = 3'd2,
		CFG_SEP_CHAR_C = 3'd3,
		CFG_SEP_CHAR_D = 3'd4
	} cfg_idx_t;

	// Scan modes, one-hot
	typedef enum logic [3:0] {
		MODE_PLAIN  = 4'b0001,
		MODE_SQUOTE = 4'b0010,
		MODE_DQUOTE = 4'b0100,
		MODE_ESCAPE = 4'b1000
	} mode_t;

	// Request payload
	typedef struct packed {
		logic [7:0] in_byte;
		logic       has_byte;
		logic       line_last;
	} req_t;

	// Result payload
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       word_close;
		logic       line_done;
		logic       needs_more;
		logic [7:0] word_total;
	} res_t;

endpackage

// ===== rtl/quoted_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_word_tokenizer
// Splits a byte stream into shell-style words with single quotes, double
// quotes and backslash escapes; one result per request.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in       request    in_valid/in_stall   qwt_pkg::req_t in_data
//  out      result     out_valid/out_stall qwt_pkg::res_t out_data
//  cfg      write      cfg_we              cfg_index, cfg_data
//
//  One request per cycle sustained while the result is not stalled; an
//  accepted request passes the input register, then the result register.
//  The mode update and separator compare sit between the two registers.
//  Reset restores separator defaults and puts the scanner in plain mode.
//  A stalled result holds; the input register still takes a request while
//  the result register can drain in the same cycle.
//
module quoted_word_tokenizer #(
	parameter int COUNT_BITS = qwt_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  qwt_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output qwt_pkg::res_t  out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [7:0]     cfg_data
);

	localparam int TW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	// Configuration registers
	logic [2:0] sep_count_q;
	logic [7:0] sep_char_q [qwt_pkg::SEP_REGS];

	// Scanner state
	qwt_pkg::mode_t          mode_q;
	logic                    ret_dq_q;
	logic                    open_q;
	logic [COUNT_BITS-1:0]   cnt_q;

	// Pipeline
	logic           valid_s1;
	qwt_pkg::req_t  data_s1;
	logic           out_valid_q;
	qwt_pkg::res_t  out_data_q;

	logic out_free;
	logic adv_s1;
	logic take_in;

	// Next-state logic
	qwt_pkg::mode_t          mode_n;
	logic                    ret_dq_n;
	logic                    open_n;
	logic [COUNT_BITS-1:0]   cnt_n;
	logic                    is_sep;
	logic                    append;
	logic                    closed;
	logic                    need;
	logic [7:0]              total;
	logic [TW-1:0]           cnt_ext;
	qwt_pkg::res_t           res;

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign take_in   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_count_q   <= qwt_pkg::SEP_COUNT_RST;
			sep_char_q[0] <= qwt_pkg::SEP_A_RST;
			sep_char_q[1] <= qwt_pkg::SEP_B_RST;
			sep_char_q[2] <= qwt_pkg::SEP_C_RST;
			sep_char_q[3] <= qwt_pkg::SEP_D_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qwt_pkg::CFG_SEP_COUNT:  sep_count_q   <= cfg_data[2:0];
				qwt_pkg::CFG_SEP_CHAR_A: sep_char_q[0] <= cfg_data;
				qwt_pkg::CFG_SEP_CHAR_B: sep_char_q[1] <= cfg_data;
				qwt_pkg::CFG_SEP_CHAR_C: sep_char_q[2] <= cfg_data;
				qwt_pkg::CFG_SEP_CHAR_D: sep_char_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Match separators: NUL always, plus the enabled registers
	always_comb begin
		is_sep = (data_s1.in_byte == qwt_pkg::CH_NUL);
		for (int i = 0; i < qwt_pkg::SEP_REGS; i++) begin
			if ((sep_count_q > 3'(i)) && (sep_char_q[i] == data_s1.in_byte)) begin
				is_sep = 1'b1;
			end
		end
	end

	// Advance the scanner by one byte, then apply line end
	always_comb begin
		mode_n   = mode_q;
		ret_dq_n = ret_dq_q;
		open_n   = open_q;
		cnt_n    = cnt_q;
		append   = 1'b0;
		closed   = 1'b0;
		need     = 1'b0;
		total    = 8'd0;
		cnt_ext  = '0;

		if (data_s1.has_byte) begin
			unique case (mode_q)
				qwt_pkg::MODE_PLAIN: begin
					if (data_s1.in_byte == qwt_pkg::CH_BACKSLASH) begin
						ret_dq_n = 1'b0;
						mode_n   = qwt_pkg::MODE_ESCAPE;
					end else if (data_s1.in_byte == qwt_pkg::CH_SQUOTE) begin
						mode_n = qwt_pkg::MODE_SQUOTE;
					end else if (data_s1.in_byte == qwt_pkg::CH_DQUOTE) begin
						mode_n = qwt_pkg::MODE_DQUOTE;
					end else if (is_sep) begin
						if (open_q) begin
							closed = 1'b1;
							open_n = 1'b0;
							if (cnt_q != '1) begin
								cnt_n = cnt_q + 1'b1;
							end
						end
					end else begin
						append = 1'b1;
					end
				end
				qwt_pkg::MODE_SQUOTE: begin
					if (data_s1.in_byte == qwt_pkg::CH_SQUOTE) begin
						mode_n = qwt_pkg::MODE_PLAIN;
					end else begin
						append = 1'b1;
					end
				end
				qwt_pkg::MODE_DQUOTE: begin
					if (data_s1.in_byte == qwt_pkg::CH_BACKSLASH) begin
						ret_dq_n = 1'b1;
						mode_n   = qwt_pkg::MODE_ESCAPE;
					end else if (data_s1.in_byte == qwt_pkg::CH_DQUOTE) begin
						mode_n = qwt_pkg::MODE_PLAIN;
					end else begin
						append = 1'b1;
					end
				end
				qwt_pkg::MODE_ESCAPE: begin
					append = 1'b1;
					mode_n = ret_dq_q ? qwt_pkg::MODE_DQUOTE : qwt_pkg::MODE_PLAIN;
				end
				default: begin
					mode_n = qwt_pkg::MODE_PLAIN;
				end
			endcase
			if (append) begin
				open_n = 1'b1;
			end
		end

		// Close the open word, report the count and return to plain mode
		if (data_s1.line_last) begin
			need = (mode_n != qwt_pkg::MODE_PLAIN);
			if (open_n) begin
				closed = 1'b1;
				if (cnt_n != '1) begin
					cnt_n = cnt_n + 1'b1;
				end
			end
			cnt_ext  = TW'(cnt_n);
			total    = (cnt_ext > TW'(255)) ? 8'hFF : cnt_ext[7:0];
			mode_n   = qwt_pkg::MODE_PLAIN;
			ret_dq_n = 1'b0;
			open_n   = 1'b0;
			cnt_n    = '0;
		end

		res.out_char   = append ? data_s1.in_byte : 8'd0;
		res.char_valid = append;
		res.word_close = closed;
		res.line_done  = data_s1.line_last;
		res.needs_more = need;
		res.word_total = total;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= qwt_pkg::MODE_PLAIN;
			ret_dq_q    <= 1'b0;
			open_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				mode_q   <= mode_n;
				ret_dq_q <= ret_dq_n;
				open_q   <= open_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= in_data;
		end
		if (adv_s1) begin
			out_data_q <= res;
		end
	end

	// Assertions
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_valid |-> out_data.out_char == 8'd0)
		else $error("dropped byte not zero");

	a_line_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.line_done |->
			!out_data.needs_more && out_data.word_total == 8'd0)
		else $error("line-end fields set off line end");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && data_s1.line_last |=>
			mode_q == qwt_pkg::MODE_PLAIN && !open_q && cnt_q == '0 && !ret_dq_q)
		else $error("scanner not cleared after line end");

endmodule
